[hw/rtl/htr_pkg.sv]
// Shared types and constants for the cubic Hermite table reader.
// No dependencies; imported by htr_table and hermite_table_reader.
package htr_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int LEN_BITS    = 13;
    localparam int POS_BITS    = 29;

    // Four taps per read, one bank per tap
    localparam int NUM_TAPS    = 4;
    localparam int BANK_BITS   = $clog2(NUM_TAPS);
    localparam int ROW_BITS    = ADDR_BITS - BANK_BITS;
    localparam int BANK_ROWS   = TABLE_DEPTH / NUM_TAPS;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = LEN_BITS;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TABLE_LENGTH,
        REG_TABLE_PRESENT
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        sample_t              data;
    } htr_wr_t;

endpackage

[hw/rtl/htr_table.sv]
// Sample table split over four banks by the low address bits.
// Depends on htr_pkg. Reads four consecutive entries per cycle while rd_en is high, registered.
module htr_table
    import htr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_base,
    input  htr_wr_t              wr,
    output sample_t              taps [NUM_TAPS]
);

    logic [ROW_BITS-1:0]  row_addr [NUM_TAPS];
    sample_t              rd_data_reg [NUM_TAPS];
    logic [BANK_BITS-1:0] rot_reg;

    // Banks below the base's lane take their entry from the next row
    always_comb
    begin
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            row_addr[k] = rd_base[ADDR_BITS-1:BANK_BITS]
                + ROW_BITS'(BANK_BITS'(k) < rd_base[BANK_BITS-1:0]);
        end
    end

    for (genvar g = 0; g < NUM_TAPS; g++)
    begin : g_bank
        sample_t mem [BANK_ROWS];

        always_ff @(posedge clk)
        begin
            if (wr.en && (wr.addr[BANK_BITS-1:0] == BANK_BITS'(g)))
            begin
                mem[wr.addr[ADDR_BITS-1:BANK_BITS]] <= wr.data;
            end
            if (rd_en)
            begin
                rd_data_reg[g] <= mem[row_addr[g]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rot_reg <= rd_base[BANK_BITS-1:0];
        end
    end

    // Undo the bank rotation: taps come out lowest address first
    always_comb
    begin
        for (int j = 0; j < NUM_TAPS; j++)
        begin
            taps[j] = rd_data_reg[rot_reg + BANK_BITS'(j)];
        end
    end

endmodule

[hw/rtl/hermite_table_reader.sv]
// Takes one item per cycle while the output is not stalled.
// Ten register stages: capture, position sum, table read, coefficients, then
// three multiply / round-and-add pairs of the Horner evaluation; the last one
// is the output register. Write items update the table in the read stage.
// Reset (rst_n, async, active low) empties the pipeline, table_length = 4,
// table_present = 0. Table contents are undefined until written.
module hermite_table_reader
    import htr_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic signed [POS_BITS-1:0]      position,
    input  logic signed [POS_BITS-1:0]      offset,
    input  logic [ADDR_BITS-1:0]            write_address,
    input  logic signed [SAMPLE_BITS-1:0]   write_value,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_BITS-1:0]   sample
);

    // Stage numbers
    localparam int S_IN   = 1;
    localparam int S_SUM  = 2;
    localparam int S_TAP  = 3;
    localparam int S_COEF = 4;
    localparam int S_MUL1 = 5;
    localparam int S_ACC1 = 6;
    localparam int S_MUL2 = 7;
    localparam int S_ACC2 = 8;
    localparam int S_MUL3 = 9;
    localparam int S_OUT  = 10;
    localparam int NUM_STAGES = S_OUT;

    localparam int SUM_BITS   = POS_BITS + 1;
    localparam int IPART_BITS = SUM_BITS - 1 - FRAC_BITS;
    localparam int T_BITS     = FRAC_BITS + 1;
    localparam int COEF_BITS  = SAMPLE_BITS + 4;
    localparam int ACC_BITS   = SAMPLE_BITS + 6;
    localparam int PROD_BITS  = ACC_BITS + T_BITS + 1;

    localparam logic signed [SUM_BITS-1:0]  SUM_ONE  = SUM_BITS'(1) << FRAC_BITS;
    localparam logic [T_BITS-1:0]           T_ONE    = T_BITS'(1) << FRAC_BITS;
    localparam logic signed [PROD_BITS-1:0] P_HALF   = PROD_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0]  Y_MAX    =
        ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [ACC_BITS-1:0]  Y_MIN    = -Y_MAX - ACC_BITS'(1);
    localparam logic [LEN_BITS-1:0]         LEN_SAT  = LEN_BITS'(TABLE_DEPTH);
    localparam logic [LEN_BITS-1:0]         LEN_MIN  = LEN_BITS'(NUM_TAPS);
    localparam logic [LEN_BITS-1:0]         IDX_SPAN = LEN_BITS'(NUM_TAPS - 1);

    // acc * t, t an unsigned fraction up to one
    function automatic logic signed [PROD_BITS-1:0] mul_t(
        input logic signed [ACC_BITS-1:0] x,
        input logic [T_BITS-1:0]          t
    );
        logic signed [PROD_BITS-1:0] xs;
        logic signed [PROD_BITS-1:0] ts;
        xs = PROD_BITS'(x);
        ts = PROD_BITS'($signed({1'b0, t}));
        return xs * ts;
    endfunction

    // Round half up and drop the fraction bits
    function automatic logic signed [ACC_BITS-1:0] rnd_frac(
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [PROD_BITS-1:0] r;
        r = (p + P_HALF) >>> FRAC_BITS;
        return ACC_BITS'(r);
    endfunction

    // ---------------- configuration ----------------
    logic [LEN_BITS-1:0] len_reg;
    logic                present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_MIN;
            present_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_TABLE_LENGTH:  len_reg     <= cfg_data;
                REG_TABLE_PRESENT: present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow ----------------
    // A stage loads when it is empty or its item moves on; bubbles close up.
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] load;

    logic func2_reg;

    always_comb
    begin
        load[NUM_STAGES] = !valid_reg[NUM_STAGES] || !out_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        valid_next[S_IN] = load[S_IN] ? in_valid : valid_reg[S_IN];
        for (int k = S_SUM; k <= NUM_STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
        // Drop write items once they have updated the table
        if (load[S_TAP])
        begin
            valid_next[S_TAP] = valid_reg[S_SUM] && (func2_reg == FUNC_READ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !load[S_IN];
    assign out_valid = valid_reg[S_OUT];

    // ---------------- stage 1: capture ----------------
    logic                          func1_reg;
    logic signed [POS_BITS-1:0]    pos1_reg;
    logic signed [POS_BITS-1:0]    off1_reg;
    logic [ADDR_BITS-1:0]          waddr1_reg;
    sample_t                       wval1_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_IN])
        begin
            func1_reg  <= func;
            pos1_reg   <= position;
            off1_reg   <= offset;
            waddr1_reg <= write_address;
            wval1_reg  <= write_value;
        end
    end

    // ---------------- stage 2: read position ----------------
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [SUM_BITS-1:0] sum2_reg;
    logic [ADDR_BITS-1:0]       waddr2_reg;
    sample_t                    wval2_reg;

    assign sum_next = SUM_BITS'(pos1_reg) + SUM_BITS'(off1_reg);

    always_ff @(posedge clk)
    begin
        if (load[S_SUM])
        begin
            func2_reg  <= func1_reg;
            sum2_reg   <= sum_next;
            waddr2_reg <= waddr1_reg;
            wval2_reg  <= wval1_reg;
        end
    end

    // Clamp the index to 1 .. length-3, length saturated to the table depth; fraction 0 below, 1 above
    logic [LEN_BITS-1:0]   len_sat;
    logic [LEN_BITS-1:0]   max_idx;
    logic [IPART_BITS-1:0] ipart;
    logic [LEN_BITS-1:0]   idx;
    logic [T_BITS-1:0]     t_next;
    logic                  zero_next;
    logic [ADDR_BITS-1:0]  base;
    htr_wr_t               wr;

    always_comb
    begin
        len_sat   = (len_reg > LEN_SAT) ? LEN_SAT : len_reg;
        max_idx   = len_sat - IDX_SPAN;
        zero_next = !present_reg || (len_reg < LEN_MIN);
        ipart     = sum2_reg[SUM_BITS-2:FRAC_BITS];
        if (sum2_reg < SUM_ONE)
        begin
            idx    = LEN_BITS'(1);
            t_next = '0;
        end
        else if (LEN_BITS'(ipart) > max_idx)
        begin
            idx    = max_idx;
            t_next = T_ONE;
        end
        else
        begin
            idx    = LEN_BITS'(ipart);
            t_next = {1'b0, sum2_reg[FRAC_BITS-1:0]};
        end
        base = ADDR_BITS'(idx - LEN_BITS'(1));
    end

    // Writes land when the item leaves the read-issue stage, in item order
    always_comb
    begin
        wr.en   = valid_reg[S_SUM] && (func2_reg == FUNC_WRITE) && load[S_TAP];
        wr.addr = waddr2_reg;
        wr.data = wval2_reg;
    end

    // ---------------- stage 3: table taps ----------------
    sample_t           taps [NUM_TAPS];
    logic [T_BITS-1:0] t3_reg;
    logic              zero3_reg;

    htr_table u_table (
        .clk     (clk),
        .rd_en   (load[S_TAP]),
        .rd_base (base),
        .wr      (wr),
        .taps    (taps)
    );

    always_ff @(posedge clk)
    begin
        if (load[S_TAP])
        begin
            t3_reg    <= t_next;
            zero3_reg <= zero_next;
        end
    end

    // ---------------- stage 4: coefficients (doubled) ----------------
    logic signed [COEF_BITS-1:0] ta, tb, tc, td;
    logic signed [COEF_BITS-1:0] c1, c2, c3;

    always_comb
    begin
        ta = COEF_BITS'(taps[0]);
        tb = COEF_BITS'(taps[1]);
        tc = COEF_BITS'(taps[2]);
        td = COEF_BITS'(taps[3]);
        c1 = tc - ta;
        c2 = (ta <<< 1) - (tb <<< 2) - tb + (tc <<< 2) - td;
        c3 = (td - ta) + (tb <<< 1) + tb - (tc <<< 1) - tc;
    end

    logic signed [ACC_BITS-1:0] a1_4_reg, a2_4_reg, a3_4_reg, b2_4_reg;
    logic [T_BITS-1:0]          t4_reg;
    logic                       zero4_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_COEF])
        begin
            a1_4_reg  <= ACC_BITS'(c1);
            a2_4_reg  <= ACC_BITS'(c2);
            a3_4_reg  <= ACC_BITS'(c3);
            b2_4_reg  <= ACC_BITS'(tb) <<< 1;
            t4_reg    <= t3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // ---------------- stage 5: A3 * t ----------------
    logic signed [PROD_BITS-1:0] p5_reg;
    logic signed [ACC_BITS-1:0]  a1_5_reg, a2_5_reg, b2_5_reg;
    logic [T_BITS-1:0]           t5_reg;
    logic                        zero5_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_MUL1])
        begin
            p5_reg    <= mul_t(a3_4_reg, t4_reg);
            a1_5_reg  <= a1_4_reg;
            a2_5_reg  <= a2_4_reg;
            b2_5_reg  <= b2_4_reg;
            t5_reg    <= t4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // ---------------- stage 6: + A2 ----------------
    logic signed [ACC_BITS-1:0] acc6_reg, a1_6_reg, b2_6_reg;
    logic [T_BITS-1:0]          t6_reg;
    logic                       zero6_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_ACC1])
        begin
            acc6_reg  <= rnd_frac(p5_reg) + a2_5_reg;
            a1_6_reg  <= a1_5_reg;
            b2_6_reg  <= b2_5_reg;
            t6_reg    <= t5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // ---------------- stage 7: * t ----------------
    logic signed [PROD_BITS-1:0] p7_reg;
    logic signed [ACC_BITS-1:0]  a1_7_reg, b2_7_reg;
    logic [T_BITS-1:0]           t7_reg;
    logic                        zero7_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_MUL2])
        begin
            p7_reg    <= mul_t(acc6_reg, t6_reg);
            a1_7_reg  <= a1_6_reg;
            b2_7_reg  <= b2_6_reg;
            t7_reg    <= t6_reg;
            zero7_reg <= zero6_reg;
        end
    end

    // ---------------- stage 8: + A1 ----------------
    logic signed [ACC_BITS-1:0] acc8_reg, b2_8_reg;
    logic [T_BITS-1:0]          t8_reg;
    logic                       zero8_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_ACC2])
        begin
            acc8_reg  <= rnd_frac(p7_reg) + a1_7_reg;
            b2_8_reg  <= b2_7_reg;
            t8_reg    <= t7_reg;
            zero8_reg <= zero7_reg;
        end
    end

    // ---------------- stage 9: * t ----------------
    logic signed [PROD_BITS-1:0] p9_reg;
    logic signed [ACC_BITS-1:0]  b2_9_reg;
    logic                        zero9_reg;

    always_ff @(posedge clk)
    begin
        if (load[S_MUL3])
        begin
            p9_reg    <= mul_t(acc8_reg, t8_reg);
            b2_9_reg  <= b2_8_reg;
            zero9_reg <= zero8_reg;
        end
    end

    // ---------------- stage 10: + 2b, halve, saturate ----------------
    logic signed [ACC_BITS-1:0]    acc_fin;
    logic signed [ACC_BITS-1:0]    y_half;
    logic signed [ACC_BITS-1:0]    y_sat;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    always_comb
    begin
        acc_fin = rnd_frac(p9_reg) + b2_9_reg;
        y_half  = (acc_fin + ACC_BITS'(1)) >>> 1;
        if (y_half > Y_MAX)
        begin
            y_sat = Y_MAX;
        end
        else if (y_half < Y_MIN)
        begin
            y_sat = Y_MIN;
        end
        else
        begin
            y_sat = y_half;
        end
        // Table absent or too short: hold the output at zero
        sample_next = zero9_reg ? '0 : SAMPLE_BITS'(y_sat);
    end

    always_ff @(posedge clk)
    begin
        if (load[S_OUT])
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

[bench/tb_hermite_table_reader.sv]
`timescale 1ns / 100ps
// Self-checking bench for hermite_table_reader: table writes, Hermite reads, clamping.
// Depends on htr_pkg and the hermite_table_reader RTL, which includes htr_table.
module tb_hermite_table_reader
    import htr_pkg::*;
();

    localparam int     PIPE_LATENCY = 9;
    localparam int     LIMIT_CYCLES = 400000;
    localparam int     RANDOM_ITEMS = 950;
    localparam int     NUM_PHASES   = 7;
    localparam longint ONE          = longint'(1) << FRAC_BITS;
    localparam longint POS_MAX      = (longint'(1) << (POS_BITS - 1)) - 1;
    localparam longint POS_MIN      = -(longint'(1) << (POS_BITS - 1));

    // Expected-sample store plus a bit-exact interpolator of its own
    class sample_scoreboard;
        sample_t             held_samples [TABLE_DEPTH];
        logic [LEN_BITS-1:0] length_reg;
        bit                  present_reg;
        sample_t             expected_samples [$];
        int                  fails;

        function new();
            length_reg  = LEN_BITS'(4);
            present_reg = 1'b0;
            fails       = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_TABLE_LENGTH:  length_reg  = data[LEN_BITS-1:0];
                REG_TABLE_PRESENT: present_reg = data[0];
                default: ;
            endcase
        endfunction

        function int table_points();
            return (length_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_reg);
        endfunction

        // Highest read index after clamping; short tables are treated as four points here
        function longint top_tap();
            return (table_points() < 4) ? 1 : longint'(table_points()) - 3;
        endfunction

        // Clamp the integer part of the read position and split off the fraction
        function void locate(input longint s, output longint idx, output longint frac);
            if (s < ONE)
            begin
                idx  = 1;
                frac = 0;
            end
            else
            begin
                idx  = s >>> FRAC_BITS;
                frac = s & (ONE - 1);
                if (idx > top_tap())
                begin
                    idx  = top_tap();
                    frac = ONE;
                end
            end
        endfunction

        function longint round_half_up(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function sample_t interpolate(logic signed [POS_BITS-1:0] pos,
                                      logic signed [POS_BITS-1:0] off);
            longint idx, frac, a, b, c, d, k1, k2, k3, acc;
            longint smax;
            smax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            if (!present_reg || table_points() < 4)
                return '0;
            locate(longint'(pos) + longint'(off), idx, frac);
            a = held_samples[int'(idx - 1)];
            b = held_samples[int'(idx)];
            c = held_samples[int'(idx + 1)];
            d = held_samples[int'(idx + 2)];
            // Coefficients in half-LSB units, then Horner in t
            k1 = c - a;
            k2 = 2 * a - 5 * b + 4 * c - d;
            k3 = (d - a) + 3 * (b - c);
            acc = round_half_up(k3 * frac, FRAC_BITS) + k2;
            acc = round_half_up(acc * frac, FRAC_BITS) + k1;
            acc = round_half_up(acc * frac, FRAC_BITS) + 2 * b;
            acc = round_half_up(acc, 1);
            if (acc > smax)
                acc = smax;
            if (acc < -smax - 1)
                acc = -smax - 1;
            return sample_t'(acc);
        endfunction

        function void note_item(logic f, logic signed [POS_BITS-1:0] pos,
                                logic signed [POS_BITS-1:0] off,
                                logic [ADDR_BITS-1:0] addr, sample_t val);
            if (f == FUNC_WRITE)
                held_samples[addr] = val;
            else
                expected_samples.push_back(interpolate(pos, off));
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (expected_samples.size() == 0)
            begin
                $error("sample: no item expected, got %0d", got);
                fails++;
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want)
            begin
                $error("sample: expected %0d, got %0d", want, got);
                fails++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wen;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          func;
    logic signed [POS_BITS-1:0]    position;
    logic signed [POS_BITS-1:0]    offset;
    logic [ADDR_BITS-1:0]          write_address;
    logic signed [SAMPLE_BITS-1:0] write_value;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] sample;

    sample_scoreboard sb = new();

    // Entries the stimulus has written; a read is only issued once its four taps are here
    bit     written [TABLE_DEPTH];
    int     items_sent;
    int     cycle_count;
    bit     quiet_run;     // no idling on either side
    int     hold_left;     // long receiver hold-off, counted down by the receiver
    int     no_gap_left;   // sender items to offer back to back
    longint win_lo;
    longint win_hi;

    hermite_table_reader uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .position      (position),
        .offset        (offset),
        .write_address (write_address),
        .write_value   (write_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[hermite_table_reader] ERROR");
        $finish;
    end

    // Receiver: random stall bursts, plus the long hold-off on request
    initial
    begin : receiver
        int burst_left;
        burst_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (!quiet_run && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Sample outputs mid-cycle: out_stall and out_valid are settled, and the
    // item is taken at the coming rising edge
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_sample(sample);

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one item and hold it until taken; leaves valid high at the accepting edge
    task automatic send_item(input logic f, input logic signed [POS_BITS-1:0] pos,
                             input logic signed [POS_BITS-1:0] off,
                             input logic [ADDR_BITS-1:0] addr, input sample_t val);
        func          <= f;
        position      <= pos;
        offset        <= off;
        write_address <= addr;
        write_value   <= val;
        in_valid      <= 1'b1;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        sb.note_item(f, pos, off, addr, val);
        if (f == FUNC_WRITE)
            written[addr] = 1'b1;
        items_sent++;
        if (no_gap_left > 0)
            no_gap_left--;
        else if (!quiet_run && $urandom_range(0, 4) == 0)
            idle_for($urandom_range(1, 4));
    endtask

    // Drop valid and hold until every expected sample is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write both registers with the block idle; writes give no result, so
    // let the pipeline run empty first
    task automatic configure(input int unsigned len, input bit present);
        drain();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_TABLE_LENGTH;
        cfg_data  <= CFG_DATA_BITS'(len);
        sb.set_register(REG_TABLE_LENGTH, CFG_DATA_BITS'(len));
        @(posedge clk);
        cfg_index <= REG_TABLE_PRESENT;
        cfg_data  <= CFG_DATA_BITS'(present);
        sb.set_register(REG_TABLE_PRESENT, CFG_DATA_BITS'(present));
        @(posedge clk);
        cfg_wen <= 1'b0;
        // Pick a narrow window of taps for large tables to keep the write count down
        if (sb.top_tap() > 24)
        begin
            win_lo = $urandom_range(1, int'(sb.top_tap()) - 16);
            win_hi = win_lo + 16;
        end
        else
        begin
            win_lo = 1;
            win_hi = sb.top_tap();
        end
    endtask

    // Read at position + offset, first writing any of the four taps not yet stored
    task automatic read_raw(input logic signed [POS_BITS-1:0] pos,
                            input logic signed [POS_BITS-1:0] off);
        longint idx, frac;
        sb.locate(longint'(pos) + longint'(off), idx, frac);
        for (longint k = idx - 1; k <= idx + 2; k++)
            if (!written[int'(k)])
                send_item(FUNC_WRITE, POS_BITS'($urandom()), POS_BITS'($urandom()),
                          ADDR_BITS'(k), rand_sample());
        send_item(FUNC_READ, pos, off, ADDR_BITS'($urandom()), rand_sample());
    endtask

    // Read at a chosen sum, split at random between position and offset
    task automatic read_at(input longint s);
        longint lo, hi, off;
        lo  = (s - POS_MAX > POS_MIN) ? s - POS_MAX : POS_MIN;
        hi  = (s - POS_MIN < POS_MAX) ? s - POS_MIN : POS_MAX;
        off = lo + longint'($urandom_range(0, int'(hi - lo)));
        read_raw(POS_BITS'(s - off), POS_BITS'(off));
    endtask

    task automatic random_item();
        int     r;
        longint top;
        r   = $urandom_range(0, 99);
        top = sb.top_tap();
        if (r < 5)
            send_item(FUNC_WRITE, POS_BITS'($urandom()), POS_BITS'($urandom()),
                      ADDR_BITS'($urandom()), rand_sample());
        else if (r < 22)
            // overwrite a tap in the active window, often just ahead of a read of it
            send_item(FUNC_WRITE, POS_BITS'($urandom()), POS_BITS'($urandom()),
                      ADDR_BITS'($urandom_range(int'(win_lo) - 1, int'(win_hi) + 2)),
                      rand_sample());
        else if (r < 36)
            read_raw(POS_BITS'($urandom()), POS_BITS'($urandom()));
        else if (r < 50)
            case ($urandom_range(0, 6))
                0: read_at(ONE - 1);
                1: read_at(ONE);
                2: read_at(ONE + 1);
                3: read_at((top << FRAC_BITS) | (ONE - 1));
                4: read_at((top + 1) << FRAC_BITS);
                5: read_at(((top + 1) << FRAC_BITS) + 1);
                default: read_at(-longint'($urandom_range(0, 1 << 20)));
            endcase
        else
            read_at((longint'($urandom_range(int'(win_lo), int'(win_hi))) << FRAC_BITS)
                    | longint'($urandom_range(0, int'(ONE) - 1)));
    endtask

    initial
    begin : stimulus
        int unsigned phase_len [NUM_PHASES];
        bit          phase_present [NUM_PHASES];
        sample_t     seed_values [8];
        int          random_start;
        bit          paused;

        phase_len     = '{4, 29, 4096, 200, 8191, 2, 11};
        phase_present = '{1, 1, 1, 0, 1, 1, 1};
        seed_values   = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                          24'sh000000, 24'sh000001, 24'shFFFFFF, 24'sh001234};

        quiet_run     = 1'b0;
        hold_left     = 0;
        no_gap_left   = 0;
        items_sent    = 0;
        paused        = 1'b0;
        win_lo        = 1;
        win_hi        = 1;
        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_index     <= REG_TABLE_LENGTH;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        func          <= FUNC_READ;
        position      <= '0;
        offset        <= '0;
        write_address <= '0;
        write_value   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the first eight taps, the first four with alternating extremes so overshoot saturates
        for (int k = 0; k < 8; k++)
            send_item(FUNC_WRITE, '0, '0, ADDR_BITS'(k), seed_values[k]);
        // Reset settings: no table attached, so zero
        read_raw(POS_BITS'(ONE + 'h8000), '0);

        configure(8, 1);
        read_raw(POS_BITS'(POS_MIN), POS_BITS'(POS_MIN));
        read_raw(POS_BITS'(POS_MAX), POS_BITS'(POS_MAX));
        read_raw('0, '0);
        read_raw(POS_BITS'(ONE), '0);
        read_raw(POS_BITS'(ONE - 1), '0);
        read_raw(POS_BITS'(ONE + 'h8000), '0);
        read_raw(POS_BITS'(6 * ONE), POS_BITS'(-3 * ONE + 'h8000));
        read_raw(POS_BITS'((5 * ONE) | (ONE - 1)), '0);
        read_raw(POS_BITS'(6 * ONE), '0);
        // Write a tap and read it straight after
        send_item(FUNC_WRITE, '0, '0, ADDR_BITS'(5), 24'sh800000);
        read_raw(POS_BITS'(4 * ONE + 'h4000), '0);

        // Too short for four taps: zero
        configure(3, 1);
        read_raw(POS_BITS'(2 * ONE), '0);
        configure(0, 1);
        read_raw(POS_BITS'(POS_MAX), '0);
        // Length beyond the table saturates to its depth
        configure(8191, 1);
        read_raw(POS_BITS'(POS_MAX), POS_BITS'(POS_MAX));
        read_raw(POS_BITS'(POS_MIN), '0);
        configure(4096, 1);
        read_at((4093 * ONE) | (ONE - 1));
        read_at(4094 * ONE);

        // Random phases through several settings; the last one runs without idling
        random_start = items_sent;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            configure(phase_len[ph], phase_present[ph]);
            quiet_run = (ph == NUM_PHASES - 1);
            if (ph == 1)
            begin
                // Receiver holds off while items keep coming, so the pipe backs up
                hold_left   = 80;
                no_gap_left = 60;
            end
            while (items_sent - random_start < (ph + 1) * RANDOM_ITEMS / NUM_PHASES)
            begin
                random_item();
                // Sender pause mid-phase until everything is back
                if (ph == 2 && !paused
                    && items_sent - random_start >= 2 * RANDOM_ITEMS / NUM_PHASES + 40)
                begin
                    paused = 1'b1;
                    drain();
                end
            end
        end

        drain();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (sb.fails == 0)
            $display("[hermite_table_reader] OK");
        else
            $display("[hermite_table_reader] ERROR");
        $finish;
    end

endmodule
